// ----- hw/rtl/rau_pkg.sv -----
package rau_pkg;

	localparam int WORD_BITS = 32;
	localparam int MAG_BITS = WORD_BITS;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int CNT_BITS = $clog2(PROD_BITS + 1);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Work handed from the front end to the reduction engine.
	typedef struct packed {
		logic [PROD_BITS:0] mn;
		logic [PROD_BITS-1:0] md;
		logic neg;
	} frac_t;

	// Split a word into sign and magnitude.
	function automatic logic [MAG_BITS:0] split_signed(input logic [31:0] v);
		logic [WORD_BITS-1:0] w;
		logic [MAG_BITS-1:0] m;
		begin
			w = v[WORD_BITS-1:0];
			m = w[WORD_BITS-1] ? (MAG_BITS'(0) - w) : w;
			if (w[WORD_BITS-1] && m == '0) begin
				split_signed = {1'b1, 1'b1, {(MAG_BITS-1){1'b0}}};
			end else begin
				split_signed = {w[WORD_BITS-1], m};
			end
		end
	endfunction

endpackage

// ----- hw/rtl/rational_arith_unit.sv -----
// Path: the front end (F_MUL1, F_MUL2, F_DONE) and queue, then gcd remainder
// steps and the two exact divisions, all in one shared divider,
// then a range check; a zero numerator or denominator skips the divider.
// Flow: one item at a time in the back end; the two-entry queue, then the front end, hold the next.
// Reset: arst_n clears all control state; the queue empties, no result is valid.
module rational_arith_unit (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [1:0] op,
	input logic [31:0] a_num,
	input logic [31:0] a_den,
	input logic [31:0] b_num,
	input logic [31:0] b_den,
	output logic res_valid,
	input logic res_stall,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic [1:0] status
);
	import rau_pkg::*;

	logic f_valid, f_stall, b_valid, b_stall;
	frac_t f_data, b_data;

	rau_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .op(op),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
	);

	rau_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_stall(f_stall),
		.in_data(f_data), .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(b_valid), .q_stall(b_stall),
		.q_data(b_data), .valid(res_valid), .stall(res_stall),
		.res_num(res_num), .res_den(res_den), .status(status)
	);

endmodule

// ----- hw/rtl/rau_front.sv -----
module rau_front (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [1:0] op,
	input logic [31:0] a_num,
	input logic [31:0] a_den,
	input logic [31:0] b_num,
	input logic [31:0] b_den,
	output logic q_valid,
	input logic q_stall,
	output rau_pkg::frac_t q_data
);
	import rau_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL1,
		F_MUL2,
		F_DONE
	} fstate_t;

	fstate_t state_q, state_d;
	logic [MAG_BITS-1:0] man_q, mad_q, mbn_q, mbd_q;
	logic san_q, sad_q, sbn_q, sbd_q;
	op_t op_q;
	logic [PROD_BITS-1:0] p1_q, p2_q, pd_q;
	logic [MAG_BITS:0] san_m, sad_m, sbn_m, sbd_m;
	logic [MAG_BITS-1:0] ma, mb, mc, md;
	logic [PROD_BITS-1:0] pa, pb;
	logic s1, s2, sdn;
	logic [PROD_BITS:0] sum;
	logic sum_neg;
	frac_t out_d;

	assign san_m = split_signed(a_num);
	assign sad_m = split_signed(a_den);
	assign sbn_m = split_signed(b_num);
	assign sbd_m = split_signed(b_den);

	// Pick multiplier operands for the first multiply step, by operation.
	always_comb begin
		ma = man_q;
		mb = mbd_q;
		mc = mad_q;
		md = mbd_q;
		unique case (op_q)
			OP_ADD, OP_SUB: begin
				ma = man_q; mb = mbd_q; mc = mbn_q; md = mad_q;
			end
			OP_MUL: begin
				ma = man_q; mb = mbn_q; mc = mad_q; md = mbd_q;
			end
			OP_DIV: begin
				ma = man_q; mb = mbd_q; mc = mbn_q; md = mad_q;
			end
			default: ;
		endcase
	end

	assign pa = PROD_BITS'(ma) * PROD_BITS'(mb);
	assign pb = PROD_BITS'(mc) * PROD_BITS'(md);

	// Combine products into a signed-magnitude fraction.
	always_comb begin
		s1 = san_q ^ sbd_q;
		s2 = sbn_q ^ sad_q;
		sdn = sad_q ^ sbd_q;
		sum = '0;
		sum_neg = 1'b0;
		out_d.md = pd_q;
		out_d.mn = {1'b0, p1_q};
		out_d.neg = 1'b0;
		unique case (op_q)
			OP_ADD, OP_SUB: begin
				if (op_q == OP_SUB) s2 = ~s2;
				if (s1 == s2) begin
					sum = {1'b0, p1_q} + {1'b0, p2_q};
					sum_neg = s1;
				end else if (p1_q >= p2_q) begin
					sum = {1'b0, p1_q - p2_q};
					sum_neg = s1;
				end else begin
					sum = {1'b0, p2_q - p1_q};
					sum_neg = s2;
				end
				out_d.mn = sum;
				out_d.neg = sum_neg ^ sdn;
			end
			OP_MUL: begin
				out_d.mn = {1'b0, p1_q};
				out_d.neg = san_q ^ sbn_q ^ sdn;
			end
			OP_DIV: begin
				out_d.mn = {1'b0, p1_q};
				out_d.md = p2_q;
				out_d.neg = san_q ^ sbd_q ^ s2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture operands, then multiply in two steps.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && valid) begin
			{san_q, man_q} <= san_m;
			{sad_q, mad_q} <= sad_m;
			{sbn_q, mbn_q} <= sbn_m;
			{sbd_q, mbd_q} <= sbd_m;
			op_q <= op_t'(op);
		end
		if (state_q == F_MUL1) begin
			p1_q <= pa;
			p2_q <= pb;
		end
		if (state_q == F_MUL2) begin
			pd_q <= PROD_BITS'(mad_q) * PROD_BITS'(mbd_q);
		end
	end

	always_comb begin
		state_d = state_q;
		stall = (state_q != F_IDLE);
		q_valid = (state_q == F_DONE);
		q_data = out_d;
		unique case (state_q)
			F_IDLE: if (valid) state_d = F_MUL1;
			F_MUL1: state_d = F_MUL2;
			F_MUL2: state_d = F_DONE;
			F_DONE: if (!q_stall) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/rau_queue.sv -----
module rau_queue (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input rau_pkg::frac_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rau_pkg::frac_t out_data
);
	import rau_pkg::*;

	frac_t mem_q [2];
	logic [1:0] cnt_q;
	logic wptr_q, rptr_q;
	logic push, pop;

	assign in_stall = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = mem_q[rptr_q];
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;

	// Advance pointers and count on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_data;
	end

endmodule

// ----- hw/rtl/rau_back.sv -----
module rau_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_stall,
	input rau_pkg::frac_t q_data,
	output logic valid,
	input logic stall,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic [1:0] status
);
	import rau_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE,
		B_GCD,
		B_DIVN,
		B_DIVD,
		B_CHECK,
		B_OUT
	} bstate_t;

	localparam int W = PROD_BITS + 1;

	bstate_t state_q, state_d;
	logic [W-1:0] y_q, mn_q, md_q, g_q;
	logic [W-1:0] quo_q, rem_q, dvd_q;
	logic [CNT_BITS:0] cnt_q;
	logic neg_q;
	logic [W:0] trial;
	logic [W-1:0] rem_sh;
	logic [W-1:0] lim;
	logic div_run;
	logic [31:0] num_q;
	logic [30:0] den_q;
	logic [1:0] stat_q;

	assign lim = W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
	assign rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, (state_q == B_GCD) ? y_q : g_q};

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				mn_q <= q_data.mn;
				md_q <= {1'b0, q_data.md};
				y_q <= {1'b0, q_data.md};
				neg_q <= q_data.neg;
				dvd_q <= q_data.mn;
				rem_q <= '0;
				cnt_q <= '0;
			end
			B_GCD, B_DIVN, B_DIVD: begin
				if (div_run) begin
					dvd_q <= {dvd_q[W-2:0], 1'b0};
					quo_q <= {quo_q[W-2:0], !trial[W]};
					rem_q <= trial[W] ? rem_sh : trial[W-1:0];
					cnt_q <= cnt_q + 1'b1;
				end else begin
					cnt_q <= '0;
					rem_q <= '0;
					if (state_q == B_GCD) begin
						if (rem_q == '0) begin
							g_q <= y_q;
							dvd_q <= mn_q;
						end else begin
							y_q <= rem_q;
							dvd_q <= y_q;
						end
					end else if (state_q == B_DIVN) begin
						mn_q <= quo_q;
						dvd_q <= md_q;
					end else begin
						md_q <= quo_q;
					end
				end
			end
			B_CHECK: begin
				num_q <= '0;
				den_q <= '0;
				stat_q <= ST_OK;
				if (md_q == '0) begin
					stat_q <= ST_ZERO_DEN;
				end else if (mn_q == '0) begin
					den_q <= 31'd1;
				end else if (md_q > lim || mn_q > lim + W'(neg_q)) begin
					stat_q <= ST_OVERFLOW;
				end else begin
					num_q <= neg_q ? 32'(32'd0 - 32'(mn_q)) : 32'(mn_q);
					den_q <= 31'(md_q);
				end
			end
			default: ;
		endcase
	end

	assign div_run = (cnt_q != (CNT_BITS+1)'(W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_stall = (state_q != B_IDLE);
		valid = (state_q == B_OUT);
		res_num = num_q;
		res_den = den_q;
		status = stat_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					if (q_data.md == '0 || q_data.mn == '0) state_d = B_CHECK;
					else state_d = B_GCD;
				end
			end
			B_GCD: if (!div_run && rem_q == '0) state_d = B_DIVN;
			B_DIVN: if (!div_run) state_d = B_DIVD;
			B_DIVD: if (!div_run) state_d = B_CHECK;
			B_CHECK: state_d = B_OUT;
			B_OUT: if (!stall) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

endmodule
